// ===== hdl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256 package
// round constants, initial hash values and the front-to-back queue entry type
// ----------------------------------------------------------------------------
package sha_pkg;

    localparam int QueueDepth = 4;
    localparam logic CmdAbsorb = 1'b0;
    localparam logic CmdFinish = 1'b1;
    localparam int PadLimit = 56;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } t_item;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage

// ===== hdl/sha_queue.sv =====
// ----------------------------------------------------------------------------
// sha256 item queue
// small register queue between the accepting front and the hashing back
// ----------------------------------------------------------------------------
module sha_queue #(
    parameter int DEPTH = sha_pkg::QueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sha_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output sha_pkg::t_item o_item,
    output logic           o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wr <= inc(r_wr);
            if (i_pop && !o_empty) r_rd <= inc(r_rd);
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule

// ===== hdl/sha_core.sv =====
// ----------------------------------------------------------------------------
// sha256 back end
// block buffer, padding, one round per cycle compression and digest output
// ----------------------------------------------------------------------------
module sha_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  sha_pkg::t_item i_item,
    output logic           o_pop,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_index,
    output logic           o_last_word,
    output logic           o_empty,
    input  logic           i_pop
);
    typedef enum logic [5:0] {
        S_TAKE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state;
    // block buffer as 16 big-endian words, one byte lane written per cycle
    logic [31:0] r_buf [16];
    logic [6:0]  r_fill;
    logic [63:0] r_bits, r_total;
    logic        r_final, r_second;
    logic [5:0]  r_pos, r_rnd;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [2:0]  r_oi;

    logic [5:0]  wr_addr;
    logic [7:0]  wr_data;
    logic        wr_en;
    logic [31:0] w_new, w_cur, t1, t2, s0, s1, b0, b1, ch, mj;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // schedule word: first 16 rounds from the shift window, then expanded
    assign s0 = ror(r_w[1], 7) ^ ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1 = ror(r_w[14], 17) ^ ror(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + s0 + r_w[9] + s1;
    assign w_cur = r_w[0];
    assign b1 = ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25);
    assign ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign b0 = ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22);
    assign mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1 = r_v[7] + b1 + ch + sha_pkg::round_k(r_rnd) + w_cur;
    assign t2 = b0 + mj;

    assign o_pop = (r_state == S_TAKE) && !i_empty;
    assign o_empty = (r_state != S_OUT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index = r_oi;
    assign o_last_word = (r_oi == 3'd7);

    // byte written to the buffer this cycle
    always_comb begin
        wr_en = 1'b0;
        wr_addr = r_pos;
        wr_data = 8'h00;
        if (o_pop && i_item.cmd == sha_pkg::CmdAbsorb) begin
            wr_en = 1'b1;
            wr_addr = r_fill[5:0];
            wr_data = i_item.data;
        end else if (o_pop) begin
            wr_en = 1'b1;
            wr_addr = r_fill[5:0];
            wr_data = 8'h80;
        end else if (r_state == S_PAD) begin
            wr_en = 1'b1;
            if (r_pos >= 6'(sha_pkg::PadLimit) && !r_second) begin
                wr_data = r_total[8'd63 - {2'b0, r_pos[2:0], 3'b0} -: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_buf[wr_addr[5:2]][5'd31 - {wr_addr[1:0], 3'b0} -: 8] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_TAKE;
            r_fill <= '0;
            r_bits <= '0;
            r_final <= 1'b0;
            r_second <= 1'b0;
            r_pos <= '0;
            r_rnd <= '0;
            r_oi <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_h(3'(i));
        end else begin
            case (r_state)
                S_TAKE: begin
                    if (o_pop) begin
                        if (i_item.cmd == sha_pkg::CmdAbsorb) begin
                            if (r_fill == 7'd63) begin
                                r_final <= 1'b0;
                                r_pos <= '0;
                                r_state <= S_LOAD;
                            end
                            r_fill <= r_fill + 7'd1;
                        end else begin
                            r_final <= 1'b1;
                            r_total <= r_bits + {55'b0, r_fill[5:0], 3'b0};
                            // no room for the length: pad out and compress twice
                            r_second <= (r_fill[5:0] >= 6'(sha_pkg::PadLimit));
                            if (r_fill[5:0] == 6'd63) begin
                                r_pos <= '0;
                                r_state <= S_LOAD;
                            end else begin
                                r_pos <= r_fill[5:0] + 6'd1;
                                r_state <= S_PAD;
                            end
                        end
                    end
                end
                S_PAD: begin
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // load window one word per cycle
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= r_buf[r_pos[3:0]];
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd15) begin
                        r_rnd <= '0;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_new;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_fill <= '0;
                    if (!r_final) begin
                        r_bits <= r_bits + 64'd512;
                        r_state <= S_TAKE;
                    end else if (r_second) begin
                        r_second <= 1'b0;
                        r_pos <= '0;
                        r_state <= S_PAD;
                    end else begin
                        r_oi <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_pop) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_h(3'(i));
                            r_bits <= '0;
                            r_final <= 1'b0;
                            r_state <= S_TAKE;
                        end
                    end
                end
                default: r_state <= S_TAKE;
            endcase
        end
    end
endmodule

// ===== hdl/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256 byte stream hasher
// hashes a message arriving one byte per item, emits eight digest words
// ----------------------------------------------------------------------------
// channel  | direction | handshake           | fields
// input    | in        | i_push / o_full     | i_command, i_data_byte
// digest   | out       | o_empty / i_pop     | o_digest_word, o_word_index, o_last_word
//
// an absorb item writes one byte into the block buffer; every 64th byte adds
// a window load, 64 rounds (one per cycle) and an add step
// a finish item pads the buffer byte by byte, runs one or two
// compressions, then holds eight words until popped
// reset returns the chaining words to the initial vector; the item queue
// keeps accepting while the back end compresses, until it fills
module sha256_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = sha_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    sha_pkg::t_item in_item, q_item;
    logic q_empty, q_pop;

    assign in_item.cmd = i_command;
    assign in_item.data = i_data_byte;

    // front: item queue
    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .i_item(in_item), .o_full(o_full),
        .i_pop(q_pop), .o_item(q_item), .o_empty(q_empty)
    );

    // back: buffer, padding and compression
    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(q_empty), .i_item(q_item), .o_pop(q_pop),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word), .o_empty(o_empty), .i_pop(i_pop)
    );
endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// sha256 byte stream hasher testbench
// drives byte messages with random gaps, predicts each digest word in a local
// sha-256 model and compares every popped word against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest;

    // clock, reset and block ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        i_command = sha_pkg::CmdAbsorb;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_pop = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // predictor state: chaining words, partial block, length of full blocks
    logic [31:0] hash_h [8];
    logic [7:0]  msg_block [64];
    int          msg_fill;
    logic [63:0] msg_bits;

    t_digest     digest_queue [$];
    int          error_count = 0;
    longint      cycle_count = 0;
    bit          hold_pop = 1'b0;
    bit          long_hold = 1'b0;

    localparam longint CycleLimit = 2_000_000;

    always #1 i_clk = ~i_clk;

    sha256_byte_stream_hasher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression of msg_block into hash_h
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int r = 0; r < 16; r++) begin
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        end
        for (int r = 16; r < 64; r++) begin
            w[r] = w[r-16] + w[r-7]
                 + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
                 + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
        end
        for (int i = 0; i < 8; i++) v[i] = hash_h[i];
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(r[5:0]) + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_h[i] += v[i];
    endtask

    task automatic start_message();
        for (int i = 0; i < 8; i++) hash_h[i] = sha_pkg::init_h(i[2:0]);
        msg_fill = 0;
        msg_bits = '0;
    endtask

    // predictor step for one accepted item
    task automatic predict_digest(input logic cmd, input logic [7:0] data);
        int          pos;
        logic [63:0] total;
        if (cmd == sha_pkg::CmdAbsorb) begin
            msg_block[msg_fill] = data;
            msg_fill++;
            if (msg_fill == 64) begin
                compress_block();
                msg_bits += 64'd512;
                msg_fill = 0;
            end
        end else begin
            pos = msg_fill;
            total = msg_bits + 64'(pos * 8);
            msg_block[pos++] = 8'h80;
            // no room for the length: an extra padding block
            if (pos > sha_pkg::PadLimit) begin
                while (pos < 64) msg_block[pos++] = 8'h00;
                compress_block();
                pos = 0;
            end
            while (pos < sha_pkg::PadLimit) msg_block[pos++] = 8'h00;
            for (int k = 0; k < 8; k++) begin
                msg_block[sha_pkg::PadLimit+k] = total[63-8*k -: 8];
            end
            compress_block();
            for (int k = 0; k < 8; k++) begin
                digest_queue.push_back('{hash_h[k], 3'(k), k == 7});
            end
            start_message();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // send one item after a random gap, wait for acceptance
    task automatic send_item(input logic cmd, input logic [7:0] data, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_command <= cmd;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_full);
        predict_digest(cmd, data);
    endtask

    // stop offering items and wait for every expected word
    task automatic wait_drained();
        i_push <= 1'b0;
        do @(posedge i_clk); while (digest_queue.size() != 0);
    endtask

    task automatic send_message(input int len, input bit fast = 0);
        for (int i = 0; i < len; i++) send_item(sha_pkg::CmdAbsorb, 8'($urandom), fast);
        send_item(sha_pkg::CmdFinish, 8'($urandom), fast);
    endtask

    // receiver: random pop stalls, plus the long hold-off
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && i_pop && !o_empty) begin
            if (digest_queue.size() == 0) begin
                report_mismatch("unexpected digest_word", o_digest_word, '0);
            end else begin
                if (o_digest_word !== digest_queue[0].word)
                    report_mismatch("digest_word", o_digest_word, digest_queue[0].word);
                if (o_word_index !== digest_queue[0].index)
                    report_mismatch("word_index", o_word_index, digest_queue[0].index);
                if (o_last_word !== digest_queue[0].last)
                    report_mismatch("last_word", o_last_word, digest_queue[0].last);
                void'(digest_queue.pop_front());
            end
        end
        if (hold_pop || long_hold) i_pop <= 1'b0;
        else i_pop <= ($urandom_range(0, 12) < 9);
    end

    initial begin
        int count;
        count = 0;
        forever begin
            @(posedge i_clk);
            if (count > 0) begin
                count--;
                hold_pop <= (count > 0);
            end else if ($urandom_range(0, 15) == 0) begin
                count = $urandom_range(0, 12);
                hold_pop <= (count > 0);
            end
        end
    end

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("== FAIL ==");
        $finish;
    end

    // every data bit and the finish with constant (ignored) data
    task automatic test_directed();
        send_item(sha_pkg::CmdFinish, 8'hff);     // empty message
        send_item(sha_pkg::CmdAbsorb, 8'h00);
        send_item(sha_pkg::CmdAbsorb, 8'hff);
        send_item(sha_pkg::CmdAbsorb, 8'ha5);
        send_item(sha_pkg::CmdAbsorb, 8'h5a);
        send_item(sha_pkg::CmdFinish, 8'h00);
        wait_drained();
    endtask

    // 63 bytes: the pad byte fills the block, the length needs a second one
    task automatic test_pad_boundaries();
        send_message(63, 1);
        wait_drained();
    endtask

    // hold off the receiver while the sender keeps pushing
    task automatic test_back_pressure();
        long_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end
            begin
                send_message(3, 1);
                send_message(0, 1);
                send_message(10, 1);
            end
        join
        wait_drained();
    endtask

    // random short messages
    task automatic test_random();
        int len;
        for (int m = 0; m < 6; m++) begin
            len = $urandom_range(0, 6);
            send_message(len);
            if ($urandom_range(0, 3) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        start_message();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pad_boundaries();
        test_back_pressure();
        test_random();
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && digest_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
